FILE: design/rgb_to_hsv_converter_defines.svh
// Assertion macros shared by the RGB to HSV converter RTL.
// No dependencies; included by rhc_div_cell, the module that carries assertions.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");

// Next-cycle implication, disabled while in reset
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");

`endif

FILE: design/rhc_pkg.sv
// Package for the RGB to HSV converter: widths and the stage payload type.
// No dependencies; used by the interfaces and all modules.
package rhc_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    // hue divisor is 6*d, which needs three more bits than a channel
    localparam int HDIV_BITS     = CHANNEL_BITS + 3;

    // Payload carried from cell to cell along the divider chain
    typedef struct packed {
        logic [CHANNEL_BITS-1:0]  value;
        logic                     full;
        logic [HDIV_BITS-1:0]     hue_rem;
        logic [HDIV_BITS-1:0]     hue_div;
        logic [CHANNEL_BITS-1:0]  sat_rem;
        logic [CHANNEL_BITS-1:0]  sat_div;
        logic [FRACTION_BITS-1:0] hue_q;
        logic [FRACTION_BITS-1:0] sat_q;
    } rhc_stage_t;

endpackage

FILE: design/rhc_interfaces.sv
// Valid/ready channel interfaces for RGB pixels and HSV results.
// Depends on rhc_pkg for the field widths.
interface rhc_pixel_if;
    import rhc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
    import rhc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  value;

    modport source (output valid, output hue, output saturation, output value, input ready);
    modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: design/rhc_front.sv
// Front stage: max/min, chroma, hue numerator and divisors, registered.
// Depends on rhc_pkg; feeds the first divider cell.
module rhc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] red,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] green,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0] blue,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output rhc_pkg::rhc_stage_t           dn_data
);
    import rhc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rhc_stage_t data_reg;
    rhc_stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Channel statistics and division setup
    always_comb
    begin
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] mn;
        logic [CHANNEL_BITS-1:0] d;
        logic [HDIV_BITS-1:0]    r_w;
        logic [HDIV_BITS-1:0]    g_w;
        logic [HDIV_BITS-1:0]    b_w;
        logic [HDIV_BITS-1:0]    d_w;
        logic [HDIV_BITS-1:0]    d6;
        logic [HDIV_BITS-1:0]    num;

        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d = mx - mn;

        r_w = HDIV_BITS'(red);
        g_w = HDIV_BITS'(green);
        b_w = HDIV_BITS'(blue);
        d_w = HDIV_BITS'(d);
        d6  = (d_w << 2) + (d_w << 1);

        // Sector numerator; ties resolve to red, then green
        if (mx == red)
        begin
            if (green >= blue)
            begin
                num = g_w - b_w;
            end
            else
            begin
                num = d6 - (b_w - g_w);
            end
        end
        else if (mx == green)
        begin
            num = ((d_w << 1) + b_w) - r_w;
        end
        else
        begin
            num = ((d_w << 2) + r_w) - g_w;
        end

        data_next.value   = mx;
        // d equal to a nonzero max gives a quotient of one, which saturates
        data_next.full    = (d == mx) && (mx != '0);
        // zero divisors become one so the zero numerators give zero quotients
        data_next.hue_div = (d == '0) ? HDIV_BITS'(1) : d6;
        data_next.hue_rem = (d == '0) ? '0 : num;
        data_next.sat_div = (mx == '0) ? CHANNEL_BITS'(1) : mx;
        data_next.sat_rem = data_next.full ? '0 : d;
        data_next.hue_q   = '0;
        data_next.sat_q   = '0;
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: design/rhc_div_cell.sv
// Divider cell: one restoring step for hue and saturation, one quotient bit each.
// Depends on rhc_pkg and rgb_to_hsv_converter_defines.svh.
`include "rgb_to_hsv_converter_defines.svh"

module rhc_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  rhc_pkg::rhc_stage_t up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output rhc_pkg::rhc_stage_t dn_data
);
    import rhc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rhc_stage_t data_reg;
    rhc_stage_t data_next;

    logic [HDIV_BITS:0]    hue_shift;
    logic [HDIV_BITS:0]    hue_diff;
    logic                  hue_take;
    logic [CHANNEL_BITS:0] sat_shift;
    logic [CHANNEL_BITS:0] sat_diff;
    logic                  sat_take;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Shift remainder, trial subtract, shift the quotient bit in
    assign hue_shift = {up_data.hue_rem, 1'b0};
    assign hue_diff  = hue_shift - {1'b0, up_data.hue_div};
    assign hue_take  = hue_shift >= {1'b0, up_data.hue_div};
    assign sat_shift = {up_data.sat_rem, 1'b0};
    assign sat_diff  = sat_shift - {1'b0, up_data.sat_div};
    assign sat_take  = sat_shift >= {1'b0, up_data.sat_div};

    always_comb
    begin
        data_next         = up_data;
        data_next.hue_rem = hue_take ? hue_diff[HDIV_BITS-1:0] : hue_shift[HDIV_BITS-1:0];
        data_next.sat_rem = sat_take ? sat_diff[CHANNEL_BITS-1:0]
                                     : sat_shift[CHANNEL_BITS-1:0];
        data_next.hue_q   = {up_data.hue_q[FRACTION_BITS-2:0], hue_take};
        data_next.sat_q   = {up_data.sat_q[FRACTION_BITS-2:0], sat_take};
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    // Remainders stay below their divisors, hue divisor never zero
    `RHC_ASSERT_IMPL(a_hue_rem_below_div, clk, rst_n, valid_reg, data_reg.hue_rem < data_reg.hue_div)
    `RHC_ASSERT_IMPL(a_sat_rem_below_div, clk, rst_n, valid_reg, data_reg.sat_rem < data_reg.sat_div)
    `RHC_ASSERT_IMPL(a_hue_div_nonzero, clk, rst_n, valid_reg, data_reg.hue_div != '0)
    // A stalled cell keeps its item
    `RHC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid_reg && !dn_ready, valid_reg && $stable(data_reg))

endmodule

FILE: design/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front stage plus a chain of divider cells.
// Depends on rhc_pkg, rhc_interfaces, rhc_front and rhc_div_cell.
//
//  channel   modport  fields                         role
//  pixel     sink     red, green, blue               one RGB pixel per transfer
//  hsv       source   hue, saturation, value         one HSV result per transfer
//
// Throughput is one pixel per cycle while the output is not stalled; the pipeline
// is one front stage, then one divider cell per quotient bit of the hue and
// saturation divisions.
// Every stage holds its own valid bit; a stalled output backs up stage by
// stage, and empty stages keep accepting while results wait.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
module rgb_to_hsv_converter
(
    input  logic        clk,
    input  logic        rst_n,
    rhc_pixel_if.sink   pixel,
    rhc_hsv_if.source   hsv
);
    import rhc_pkg::*;

    logic       stage_valid [FRACTION_BITS+1];
    logic       stage_ready [FRACTION_BITS+1];
    rhc_stage_t stage_data  [FRACTION_BITS+1];

    // Front stage
    rhc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel.valid),
        .up_ready (pixel.ready),
        .red      (pixel.red),
        .green    (pixel.green),
        .blue     (pixel.blue),
        .dn_valid (stage_valid[0]),
        .dn_ready (stage_ready[0]),
        .dn_data  (stage_data[0])
    );

    // Divider cell chain, one quotient bit per cell
    for (genvar i = 0; i < FRACTION_BITS; i++)
    begin : g_cell
        rhc_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_data  (stage_data[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_data  (stage_data[i+1])
        );
    end

    // Output from the last cell; full chroma saturates
    assign hsv.valid                  = stage_valid[FRACTION_BITS];
    assign stage_ready[FRACTION_BITS] = hsv.ready;
    assign hsv.hue                    = stage_data[FRACTION_BITS].hue_q;
    assign hsv.saturation             = stage_data[FRACTION_BITS].full ? '1
                                      : stage_data[FRACTION_BITS].sat_q;
    assign hsv.value                  = stage_data[FRACTION_BITS].value;

endmodule

FILE: bench/tb_rgb_to_hsv_converter.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_converter: directed and random RGB pixels
// checked against an in-bench HSV predictor. Depends on rhc_pkg and rhc_interfaces.
module tb_rgb_to_hsv_converter;
    import rhc_pkg::*;

    localparam int RANDOM_PIXELS  = 1500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = FRACTION_BITS + 16;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0]  value;
    } hsv_t;

    logic clk;
    logic rst_n;

    rhc_pixel_if pixel_ch ();
    rhc_hsv_if   hsv_ch ();

    rgb_to_hsv_converter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .hsv   (hsv_ch)
    );

    rgb_t pending_pixels[$];
    hsv_t expected_hsv[$];
    int   total_pixels;
    int   directed_pixels;
    int   pixels_sent;
    int   results_checked;
    int   mismatches;
    int   quiet_cycles;

    // Clock: 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // HSV of one pixel: hue and saturation in turns/fraction, truncated
    function automatic hsv_t predict_hsv(input rgb_t px);
        hsv_t                  res;
        longint unsigned       r, g, b, top, bottom, chroma, sat, hue, num;
        longint unsigned       one;
        begin
            one    = 64'd1 << FRACTION_BITS;
            r      = 64'(px.red);
            g      = 64'(px.green);
            b      = 64'(px.blue);
            top    = r;
            bottom = r;
            if (g > top) top = g;
            if (b > top) top = b;
            if (g < bottom) bottom = g;
            if (b < bottom) bottom = b;
            chroma = top - bottom;

            // black gives zero saturation; d == value clips to all ones
            if (top == 0)
                sat = 0;
            else
                sat = (chroma * one) / top;
            if (sat > one - 1) sat = one - 1;

            // grey gives zero hue; sector picked red, then green, then blue
            hue = 0;
            if (chroma != 0)
            begin
                if (top == r)
                    num = (g >= b) ? (g - b) : (6 * chroma - (b - g));
                else if (top == g)
                    num = (2 * chroma + b) - r;
                else
                    num = (4 * chroma + r) - g;
                hue = (num * one) / (6 * chroma);
                if (hue > one - 1) hue = one - 1;
            end

            res.hue        = hue[FRACTION_BITS-1:0];
            res.saturation = sat[FRACTION_BITS-1:0];
            res.value      = top[CHANNEL_BITS-1:0];
            return res;
        end
    endfunction

    // Idle percentages: sender/receiver 21/54, then 54/21, then none
    function automatic int sender_idle_pct(input int sent);
        if (sent < total_pixels / 3)
            return 21;
        else if (sent < (2 * total_pixels) / 3)
            return 54;
        else
            return 0;
    endfunction

    function automatic int receiver_idle_pct(input int sent);
        if (sent < total_pixels / 3)
            return 54;
        else if (sent < (2 * total_pixels) / 3)
            return 21;
        else
            return 0;
    endfunction

    // Random pixel, biased toward grey, ties, zero channels and extremes
    function automatic rgb_t random_pixel();
        rgb_t px;
        logic [CHANNEL_BITS-1:0] level;
        begin
            px.red   = CHANNEL_BITS'($urandom_range(CHAN_MAX));
            px.green = CHANNEL_BITS'($urandom_range(CHAN_MAX));
            px.blue  = CHANNEL_BITS'($urandom_range(CHAN_MAX));
            level    = CHANNEL_BITS'($urandom_range(CHAN_MAX));
            case ($urandom_range(9))
                0: px = '{level, level, level};
                1: px.green = px.red;
                2: px.blue = px.green;
                3: px.blue = px.red;
                4:
                begin
                    case ($urandom_range(2))
                        0: px.red = '0;
                        1: px.green = '0;
                        default: px.blue = '0;
                    endcase
                end
                5:
                begin
                    px.red   = $urandom_range(1) ? CHAN_MAX : '0;
                    px.green = $urandom_range(1) ? CHAN_MAX : '0;
                    px.blue  = $urandom_range(1) ? CHAN_MAX : '0;
                end
                6:
                begin
                    // near grey: chroma of one
                    px = '{level, level, level};
                    if (level == CHAN_MAX)
                        px.blue = level - CHANNEL_BITS'(1);
                    else
                        px.green = level + CHANNEL_BITS'(1);
                end
                default: ;
            endcase
            return px;
        end
    endfunction

    // Pixel driver: presents queued pixels, predicts each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                expected_hsv.push_back(predict_hsv('{pixel_ch.red, pixel_ch.green,
                                                     pixel_ch.blue}));
                pixels_sent <= pixels_sent + 1;
            end
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (pending_pixels.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct(pixels_sent))
                begin
                    rgb_t px;
                    px = pending_pixels.pop_front();
                    pixel_ch.valid <= 1'b1;
                    pixel_ch.red   <= px.red;
                    pixel_ch.green <= px.green;
                    pixel_ch.blue  <= px.blue;
                end
                else
                begin
                    pixel_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random backpressure, field-by-field compare in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_ch.ready <= 1'b0;
        end
        else
        begin
            if (hsv_ch.valid && hsv_ch.ready)
            begin
                hsv_t want;
                if (expected_hsv.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected none, actual hue=%h sat=%h value=%h", $time,
                             hsv_ch.hue, hsv_ch.saturation, hsv_ch.value);
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    results_checked++;
                    if (want.hue !== hsv_ch.hue || want.saturation !== hsv_ch.saturation ||
                        want.value !== hsv_ch.value)
                    begin
                        mismatches++;
                        // fields shown as hue/saturation/value
                        $display("%0t: result %0d expected %h/%h/%h actual %h/%h/%h",
                                 $time, results_checked,
                                 want.hue, want.saturation, want.value,
                                 hsv_ch.hue, hsv_ch.saturation, hsv_ch.value);
                    end
                end
            end
            hsv_ch.ready <= ($urandom_range(99) >= receiver_idle_pct(pixels_sent));
        end
    end

    // Watchdog: abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_ch.valid && pixel_ch.ready) || (hsv_ch.valid && hsv_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[rgb_to_hsv_converter] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        rst_n            = 1'b0;
        pixel_ch.valid   = 1'b0;
        pixel_ch.red     = '0;
        pixel_ch.green   = '0;
        pixel_ch.blue    = '0;
        hsv_ch.ready     = 1'b0;
        pixels_sent      = 0;
        results_checked  = 0;
        mismatches       = 0;
        quiet_cycles     = 0;

        // black, grey, full saturation, each sector, ties and red wraparound
        pending_pixels.push_back('{8'd0,   8'd0,   8'd0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255});
        pending_pixels.push_back('{8'd128, 8'd128, 8'd128});
        pending_pixels.push_back('{8'd255, 8'd0,   8'd0});
        pending_pixels.push_back('{8'd0,   8'd255, 8'd0});
        pending_pixels.push_back('{8'd0,   8'd0,   8'd255});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd0});
        pending_pixels.push_back('{8'd0,   8'd255, 8'd255});
        pending_pixels.push_back('{8'd255, 8'd0,   8'd255});
        pending_pixels.push_back('{8'd255, 8'd0,   8'd1});
        pending_pixels.push_back('{8'd255, 8'd1,   8'd0});
        pending_pixels.push_back('{8'd1,   8'd0,   8'd0});
        pending_pixels.push_back('{8'd1,   8'd1,   8'd0});
        pending_pixels.push_back('{8'd0,   8'd1,   8'd1});
        pending_pixels.push_back('{8'd1,   8'd0,   8'd1});
        pending_pixels.push_back('{8'd0,   8'd0,   8'd1});
        pending_pixels.push_back('{8'd255, 8'd254, 8'd254});
        pending_pixels.push_back('{8'd254, 8'd255, 8'd255});
        pending_pixels.push_back('{8'd200, 8'd100, 8'd50});
        pending_pixels.push_back('{8'd50,  8'd200, 8'd100});
        pending_pixels.push_back('{8'd100, 8'd50,  8'd200});
        pending_pixels.push_back('{8'd10,  8'd20,  8'd30});
        pending_pixels.push_back('{8'd255, 8'd128, 8'd0});
        pending_pixels.push_back('{8'd170, 8'd85,  8'd85});
        directed_pixels = pending_pixels.size();

        repeat (RANDOM_PIXELS)
            pending_pixels.push_back(random_pixel());
        total_pixels = pending_pixels.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all transfers in, all results out, then let the pipe drain
        while (pixels_sent < total_pixels || expected_hsv.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_hsv.size() > 0)
        begin
            mismatches += expected_hsv.size();
            $display("%0t: %0d expected results never arrived", $time, expected_hsv.size());
        end

        $display("Covered %0d pixels (%0d directed, %0d random) over three handshake phases.",
                 total_pixels, directed_pixels, total_pixels - directed_pixels);
        $display("Checked %0d results, %0d failures.", results_checked, mismatches);
        if (mismatches == 0)
            $display("[rgb_to_hsv_converter] OK");
        else
            $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

endmodule
